// ----- hw/rtl/fske_pkg.sv -----
// ----------------------------------------------------------------------------
// fske_pkg
// Shared types and constants of the strided FASTA k-mer extractor.
// ----------------------------------------------------------------------------
package fske_pkg;

  // Length of one k-mer in bases.
  localparam int KMER_LEN = 31;
  // Width of a window pointer and of a count that can hold KMER_LEN itself.
  localparam int PTR_W = (KMER_LEN > 1) ? $clog2(KMER_LEN) : 1;
  localparam int CNT_W = $clog2(KMER_LEN + 1);

  // Configuration register widths and indexes.
  localparam int STRIDE_W  = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK   = 1'd1;
  localparam logic [STRIDE_W-1:0]  STRIDE_RST = 5'd31;

  // Input operations.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Characters with a meaning in the stream.
  localparam logic [7:0] CH_HEADER  = 8'h3E;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_MARK    = 8'h3D;

  // Input transaction payload.
  typedef struct packed {
    logic       op;
    logic [7:0] in_byte;
  } fske_in_t;

  // Output transaction payload.
  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } fske_out_t;

endpackage

// ----- hw/rtl/fasta_strided_kmer_extractor_core.sv -----
// ----------------------------------------------------------------------------
// fasta_strided_kmer_extractor_core
// Skips FASTA headers and emits strided k-mers of the sequence bases, one
// character per output transaction, from a circular window memory.
// ----------------------------------------------------------------------------
// Order: a k-mer start enters S_KMER, the window entry goes to the read data
//   register, then the character to the output register; inputs wait meanwhile.
// Throughput: one character per cycle while emitting and out_ready_i is high,
//   set by the single read port of the window memory.
// Reset: control state clears and the registers return to stride 31 with
//   marking off at once; the window memory is not cleared, since every entry
//   is rewritten before it is read.
module fasta_strided_kmer_extractor_core
  import fske_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fske_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fske_out_t            out_data_o
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_MARK_EQ = 5'b00010,
    S_MARK_NL = 5'b00100,
    S_KMER    = 5'b01000,
    S_KMER_NL = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [STRIDE_W-1:0] stride_q;
  logic                mark_q;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [STRIDE_W-1:0] phase_q, phase_d;
  logic                unemit_q, unemit_d;
  logic                in_seq_q, in_seq_d;
  logic                pend_q, pend_d;
  logic [PTR_W-1:0]    wptr_q, wptr_d;
  logic [PTR_W-1:0]    raddr_q, raddr_d;
  logic [CNT_W-1:0]    rd_left_q, rd_left_d;
  logic [CNT_W-1:0]    ld_left_q, ld_left_d;
  logic                rdv_q, rdv_d;
  logic                out_valid_q, out_valid_d;
  fske_out_t           out_q, out_d;

  logic [7:0] mem [KMER_LEN];
  logic [7:0] rdata_q;

  logic             accept;
  logic             can_load;
  logic             rd_en;
  logic             wr_en;
  logic             has_tail;
  logic [PTR_W-1:0] wptr_inc;
  logic [PTR_W-1:0] raddr_inc;
  logic [CNT_W-1:0] fill_inc;
  logic [STRIDE_W-1:0] phase_inc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign can_load    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign has_tail  = (fill_q == CNT_W'(KMER_LEN)) && unemit_q;
  assign wptr_inc  = (wptr_q == PTR_W'(KMER_LEN - 1)) ? '0 : wptr_q + PTR_W'(1);
  assign raddr_inc = (raddr_q == PTR_W'(KMER_LEN - 1)) ? '0 : raddr_q + PTR_W'(1);
  assign fill_inc  = fill_q + CNT_W'(1);
  assign phase_inc = phase_q + STRIDE_W'(1);

  // Read the next window entry whenever the read data register is free.
  assign rd_en = (state_q == S_KMER) && (rd_left_q != '0) && (!rdv_q || can_load);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= STRIDE_RST;
      mark_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STRIDE: stride_q <= cfg_wdata_i[STRIDE_W-1:0];
        CFG_MARK:   mark_q   <= cfg_wdata_i[0];
        default:    ;
      endcase
    end
  end

  // Window memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wptr_q] <= in_data_i.in_byte;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr_q];
    end
  end

  // Input decoding, window bookkeeping and the emission sequencer.
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    phase_d     = phase_q;
    unemit_d    = unemit_q;
    in_seq_d    = in_seq_q;
    pend_d      = pend_q;
    wptr_d      = wptr_q;
    raddr_d     = rd_en ? raddr_inc : raddr_q;
    rd_left_d   = rd_en ? rd_left_q - CNT_W'(1) : rd_left_q;
    ld_left_d   = ld_left_q;
    rdv_d       = rd_en ? 1'b1 : ((rdv_q && can_load) ? 1'b0 : rdv_q);
    out_valid_d = (out_valid_q && out_ready_i) ? 1'b0 : out_valid_q;
    out_d       = out_q;
    wr_en       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.op == OP_END || in_data_i.in_byte == CH_HEADER) begin
            // Record boundary or end of input: optional marker, tail, clear.
            if (in_data_i.op == OP_BYTE && mark_q) begin
              state_d = S_MARK_EQ;
              pend_d  = has_tail;
            end else if (has_tail) begin
              state_d = S_KMER;
            end
            raddr_d   = wptr_q;
            rd_left_d = CNT_W'(KMER_LEN);
            ld_left_d = CNT_W'(KMER_LEN);
            fill_d    = '0;
            phase_d   = '0;
            unemit_d  = 1'b0;
            in_seq_d  = 1'b0;
          end else if (in_data_i.in_byte == CH_NEWLINE) begin
            in_seq_d = 1'b1;
          end else if (in_seq_q) begin
            // A base: store it and decide whether a k-mer starts here.
            wr_en     = 1'b1;
            wptr_d    = wptr_inc;
            raddr_d   = wptr_inc;
            rd_left_d = CNT_W'(KMER_LEN);
            ld_left_d = CNT_W'(KMER_LEN);
            if (fill_q < CNT_W'(KMER_LEN)) begin
              fill_d = fill_inc;
              if (fill_inc == CNT_W'(KMER_LEN)) begin
                phase_d  = '0;
                unemit_d = 1'b0;
                state_d  = S_KMER;
              end
            end else if (phase_inc >= stride_q) begin
              phase_d  = '0;
              unemit_d = 1'b0;
              state_d  = S_KMER;
            end else begin
              phase_d  = phase_inc;
              unemit_d = 1'b1;
            end
          end
        end
      end
      S_MARK_EQ: begin
        if (can_load) begin
          out_valid_d   = 1'b1;
          out_d.out_char = CH_MARK;
          out_d.last    = 1'b0;
          state_d       = S_MARK_NL;
        end
      end
      S_MARK_NL: begin
        if (can_load) begin
          out_valid_d   = 1'b1;
          out_d.out_char = CH_NEWLINE;
          out_d.last    = !pend_q;
          state_d       = pend_q ? S_KMER : S_IDLE;
        end
      end
      S_KMER: begin
        if (rdv_q && can_load) begin
          out_valid_d    = 1'b1;
          out_d.out_char = rdata_q;
          out_d.last     = 1'b0;
          ld_left_d      = ld_left_q - CNT_W'(1);
          if (ld_left_q == CNT_W'(1)) begin
            state_d = S_KMER_NL;
          end
        end
      end
      S_KMER_NL: begin
        if (can_load) begin
          out_valid_d    = 1'b1;
          out_d.out_char = CH_NEWLINE;
          out_d.last     = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      phase_q     <= '0;
      unemit_q    <= 1'b0;
      in_seq_q    <= 1'b0;
      pend_q      <= 1'b0;
      wptr_q      <= '0;
      raddr_q     <= '0;
      rd_left_q   <= '0;
      ld_left_q   <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      phase_q     <= phase_d;
      unemit_q    <= unemit_d;
      in_seq_q    <= in_seq_d;
      pend_q      <= pend_d;
      wptr_q      <= wptr_d;
      raddr_q     <= raddr_d;
      rd_left_q   <= rd_left_d;
      ld_left_q   <= ld_left_d;
      rdv_q       <= rdv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule
